/* hw/rtl/ecq_pkg.sv */
// Shared types and constants for the elevator call queue.
`timescale 1ns / 1ps

package ecq_pkg;

  localparam int NUM_FLOORS = 4;
  localparam int FLOOR_W    = 2;   // bits to name one floor
  localparam int CNT_W      = 3;   // queue fill count, 0..NUM_FLOORS

  localparam int IN_W  = 24;       // input tdata width (23 used bits)
  localparam int OUT_W = 16;       // output tdata width (16 used bits)

  // Input tdata field offsets, lowest first
  localparam int IN_HALL_UP_LSB   = 0;
  localparam int IN_HALL_DN_LSB   = 4;
  localparam int IN_CAB_LSB       = 8;
  localparam int IN_SENSOR_LSB    = 12;
  localparam int IN_STOPPED_BIT   = 15;
  localparam int IN_CAR_FLOOR_LSB = 16;
  localparam int IN_MOTOR_DIR_LSB = 18;
  localparam int IN_REM_VALID_BIT = 20;
  localparam int IN_REM_FLOOR_LSB = 21;

  // Motor direction codes
  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // Head of queue when empty (-1)
  localparam logic [2:0] NO_TARGET = 3'b111;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;    // capture input transaction, latch hall calls
    logic add_start;  // clear the floor scan counter
    logic add_step;   // test one cab button and append it if new
    logic remove;     // drop the requested floor from the queue
    logic load_out;   // capture result into the output register
  } ecq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic add_last;   // scan counter sits on the top floor
  } ecq_sts_t;

endpackage

/* hw/rtl/elevator_call_queue_unit.sv */
// Top level of the elevator call queue: hall latches, cab target queue, stop decision.
`timescale 1ns / 1ps

//  channel  | direction | payload
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | one tick of button, sensor and motor inputs
//  m_axis   | out       | stop decision, lamp bitmaps and queue head
//
//  Each tick runs from accept to result through a capture step, a cab scan
//  of every floor (one floor per cycle through the shared append step), a
//  removal step and a result step.
//  Synchronous active-high reset empties the queue and clears all hall calls.
//  A finished result waits in the output register; the next tick is taken
//  while it waits, and the result cycle holds only if that register is full.

module elevator_call_queue_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // [3:0] hall_up_buttons, [7:4] hall_down_buttons, [11:8] cab_buttons,
  // [14:12] floor_sensor, [15] stopped, [17:16] car_floor, [19:18] motor_dir,
  // [20] remove_valid, [22:21] remove_floor, [23] zero
  input  logic [ecq_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [0] stop_here, [4:1] up_lamps, [8:5] down_lamps, [12:9] cab_lamps,
  // [15:13] next_target
  output logic [ecq_pkg::OUT_W-1:0]  m_tdata
);
  import ecq_pkg::*;

  ecq_cmd_t cmd;
  ecq_sts_t sts;

  // sequencing: idle -> capture -> scan floors -> remove -> result
  ecq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // all payload and queue state
  ecq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (s_tdata),
    .out_data (m_tdata)
  );

endmodule

/* hw/rtl/ecq_datapath.sv */
// Datapath: input register, hall-call latches, target queue and result register.
`timescale 1ns / 1ps

module ecq_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  ecq_pkg::ecq_cmd_t        cmd,
  output ecq_pkg::ecq_sts_t        sts,
  input  logic [ecq_pkg::IN_W-1:0] in_data,
  output logic [ecq_pkg::OUT_W-1:0] out_data
);
  import ecq_pkg::*;

  // captured transaction
  logic [NUM_FLOORS-1:0] cab_r;
  logic [2:0]            sensor_r;
  logic [FLOOR_W-1:0]    car_floor_r;
  logic [1:0]            motor_dir_r;
  logic                  rem_valid_r;
  logic [FLOOR_W-1:0]    rem_floor_r;

  // persistent state
  logic [NUM_FLOORS-1:0] up_calls;
  logic [NUM_FLOORS-1:0] down_calls;
  logic [FLOOR_W-1:0]    queue [NUM_FLOORS];
  logic [CNT_W-1:0]      count;
  logic [FLOOR_W-1:0]    scan_floor;

  logic [NUM_FLOORS-1:0] up_calls_next;
  logic [NUM_FLOORS-1:0] down_calls_next;
  logic [FLOOR_W-1:0]    queue_next [NUM_FLOORS];
  logic [CNT_W-1:0]      count_next;
  logic [OUT_W-1:0]      result;

  // incoming fields for the hall latch
  logic [NUM_FLOORS-1:0] in_up, in_dn;
  logic [2:0]            in_sensor;
  logic                  in_at_floor, in_stopped;

  // sensor decode of the captured item
  logic                  at_floor;
  logic [FLOOR_W-1:0]    sensed;

  assign in_up       = in_data[IN_HALL_UP_LSB +: NUM_FLOORS];
  assign in_dn       = in_data[IN_HALL_DN_LSB +: NUM_FLOORS];
  assign in_sensor   = in_data[IN_SENSOR_LSB +: 3];
  assign in_stopped  = in_data[IN_STOPPED_BIT];
  assign in_at_floor = ~in_sensor[2];

  assign at_floor = ~sensor_r[2];
  assign sensed   = sensor_r[FLOOR_W-1:0];

  assign sts.add_last = (scan_floor == FLOOR_W'(NUM_FLOORS - 1));

  // hall latch: skip the floor where the car stands stopped, and the top up and bottom down buttons
  always_comb begin
    up_calls_next   = up_calls;
    down_calls_next = down_calls;
    for (int f = 0; f < NUM_FLOORS; f++) begin
      if (!(in_stopped && in_at_floor && in_sensor[FLOOR_W-1:0] == FLOOR_W'(f))) begin
        if (f != NUM_FLOORS - 1 && in_up[f]) up_calls_next[f] = 1'b1;
        if (f != 0 && in_dn[f])              down_calls_next[f] = 1'b1;
      end
    end
  end

  // queue update: one append step or one removal
  always_comb begin
    logic                  present;
    logic                  press;
    logic [NUM_FLOORS-1:0] hit;
    logic                  shifting;
    present    = 1'b0;
    press      = 1'b0;
    hit        = '0;
    shifting   = 1'b0;
    count_next = count;
    for (int i = 0; i < NUM_FLOORS; i++) queue_next[i] = queue[i];

    if (cmd.add_step) begin
      press = cab_r[scan_floor] && !(at_floor && sensed == scan_floor);
      for (int i = 0; i < NUM_FLOORS; i++) begin
        if (CNT_W'(i) < count && queue[i] == scan_floor) present = 1'b1;
      end
      if (press && !present && count != CNT_W'(NUM_FLOORS)) begin
        queue_next[count[FLOOR_W-1:0]] = scan_floor;
        count_next = count + CNT_W'(1);
      end
    end else if (cmd.remove && rem_valid_r) begin
      for (int i = 0; i < NUM_FLOORS; i++) begin
        hit[i] = (CNT_W'(i) < count) && (queue[i] == rem_floor_r);
      end
      // entries at and behind the hit move one place forward
      for (int i = 0; i < NUM_FLOORS; i++) begin
        shifting = shifting | hit[i];
        if (shifting) begin
          queue_next[i] = (i < NUM_FLOORS - 1) ? queue[(i + 1) % NUM_FLOORS] : '0;
        end
      end
      if (hit != '0) count_next = count - CNT_W'(1);
    end
  end

  // result from the settled state
  always_comb begin
    logic                  stop;
    logic [NUM_FLOORS-1:0] cab_l;
    logic [2:0]            head;
    stop  = 1'b0;
    cab_l = '0;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      if (CNT_W'(i) < count) begin
        if (at_floor && queue[i] == sensed) stop = 1'b1;
        else cab_l[queue[i]] = 1'b1;
      end
    end
    // head of the queue is the car floor and the car is sensed there
    if (at_floor && count != '0 && queue[0] == car_floor_r && sensed == car_floor_r)
      stop = 1'b1;
    if (at_floor && motor_dir_r == DIR_UP   && up_calls[sensed])   stop = 1'b1;
    if (at_floor && motor_dir_r == DIR_DOWN && down_calls[sensed]) stop = 1'b1;
    head   = (count != '0) ? {1'b0, queue[0]} : NO_TARGET;
    result = {head, cab_l,
              down_calls & ~NUM_FLOORS'(1),
              up_calls & ~(NUM_FLOORS'(1) << (NUM_FLOORS - 1)),
              stop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_calls   <= '0;
      down_calls <= '0;
      count      <= '0;
      scan_floor <= '0;
    end else begin
      if (cmd.load_in) begin
        up_calls   <= up_calls_next;
        down_calls <= down_calls_next;
      end
      if (cmd.add_start) scan_floor <= '0;
      else if (cmd.add_step) scan_floor <= scan_floor + FLOOR_W'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_FLOORS; i++) queue[i] <= queue_next[i];
    if (cmd.load_in) begin
      cab_r       <= in_data[IN_CAB_LSB +: NUM_FLOORS];
      sensor_r    <= in_sensor;
      car_floor_r <= in_data[IN_CAR_FLOOR_LSB +: FLOOR_W];
      motor_dir_r <= in_data[IN_MOTOR_DIR_LSB +: 2];
      rem_valid_r <= in_data[IN_REM_VALID_BIT];
      rem_floor_r <= in_data[IN_REM_FLOOR_LSB +: FLOOR_W];
    end
    if (cmd.load_out) out_data <= result;
  end

endmodule

/* hw/rtl/ecq_ctrl.sv */
// Controller: sequences capture, cab scan, removal and result handoff.
`timescale 1ns / 1ps

module ecq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output ecq_pkg::ecq_cmd_t  cmd,
  input  ecq_pkg::ecq_sts_t  sts
);
  import ecq_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ADD    = 2'd1;
  localparam logic [1:0] ST_REMOVE = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state, state_next;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in   = 1'b1;
          cmd.add_start = 1'b1;
          state_next    = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add_step = 1'b1;
        if (sts.add_last) state_next = ST_REMOVE;
      end
      ST_REMOVE: begin
        cmd.remove = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

/* hw/rtl/ecq_checker.sv */
// Port-level checks for the elevator call queue, bound to the top level.
`timescale 1ns / 1ps

module ecq_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [ecq_pkg::OUT_W-1:0] m_tdata
);
  import ecq_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one tick at a time: busy the cycle after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a tick is in flight");

  // top up lamp and bottom down lamp stay dark; head is a floor or empty
  a_lamps_and_head: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[4] && !m_tdata[5]
                 && (!m_tdata[15] || m_tdata[15:13] == NO_TARGET))
    else $error("bad lamp or queue head");

endmodule

bind elevator_call_queue_unit ecq_checker u_ecq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* sim/elevator_call_queue_unit_test.sv */
// Self-checking testbench for elevator_call_queue_unit: directed and random ticks, scored per field.
`timescale 1ns / 1ps

module elevator_call_queue_unit_test;

  import ecq_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any transaction
  localparam int HOLD_CYCLES    = 150;   // long receiver hold-off
  localparam int DRAIN_CYCLES   = 20;    // settle time for stray late results

  // One expected result, fields as they leave the block
  typedef struct packed {
    logic       stop_here;
    logic [3:0] up_lamps;
    logic [3:0] down_lamps;
    logic [3:0] cab_lamps;
    logic [2:0] next_target;
  } lamp_status_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  // Stimulus and scoreboard storage
  logic [IN_W-1:0] pending_ticks[$];
  lamp_status_t    expected_status[$];

  // Shadow of the dispatcher state
  logic [3:0] model_up_calls = '0;
  logic [3:0] model_down_calls = '0;
  logic [1:0] model_targets[NUM_FLOORS];
  int         model_target_cnt = 0;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  logic hold_rx = 1'b0;
  int mismatch_cnt = 0;
  int quiet_cycles = 0;

  elevator_call_queue_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic target_queued(input logic [1:0] floor_id);
    logic found;
    found = 1'b0;
    for (int i = 0; i < model_target_cnt; i++)
      if (model_targets[i] == floor_id) found = 1'b1;
    return found;
  endfunction

  // Apply one accepted tick to the shadow state and queue its result.
  task automatic dispatch_tick(input logic [IN_W-1:0] w);
    logic [3:0]   hall_up, hall_dn, cab;
    logic [2:0]   sensor;
    logic [1:0]   here, car, dir, rem_floor;
    logic         stopped, rem_valid, at_floor;
    int           hit;
    lamp_status_t st;
    begin
      hall_up   = w[IN_HALL_UP_LSB +: 4];
      hall_dn   = w[IN_HALL_DN_LSB +: 4];
      cab       = w[IN_CAB_LSB +: 4];
      sensor    = w[IN_SENSOR_LSB +: 3];
      stopped   = w[IN_STOPPED_BIT];
      car       = w[IN_CAR_FLOOR_LSB +: FLOOR_W];
      dir       = w[IN_MOTOR_DIR_LSB +: 2];
      rem_valid = w[IN_REM_VALID_BIT];
      rem_floor = w[IN_REM_FLOOR_LSB +: FLOOR_W];
      // negative sensor codes read as raw values >= 4: between floors
      at_floor  = (sensor < 3'(NUM_FLOORS));
      here      = sensor[1:0];

      // hall latching, masked at the floor where the car is stopped
      for (int f = 0; f < NUM_FLOORS; f++) begin
        if (!(stopped && at_floor && here == f[1:0])) begin
          if (f != NUM_FLOORS - 1 && hall_up[f]) model_up_calls[f] = 1'b1;
          if (f != 0 && hall_dn[f]) model_down_calls[f] = 1'b1;
        end
      end

      // cab presses in ascending order, no duplicates, none at the sensed floor
      for (int f = 0; f < NUM_FLOORS; f++) begin
        if (cab[f] && !(at_floor && here == f[1:0]) && !target_queued(f[1:0]) &&
            model_target_cnt < NUM_FLOORS) begin
          model_targets[model_target_cnt] = f[1:0];
          model_target_cnt++;
        end
      end

      // removal keeps every other entry, the last one included
      if (rem_valid) begin
        hit = -1;
        for (int i = 0; i < model_target_cnt; i++)
          if (hit < 0 && model_targets[i] == rem_floor) hit = i;
        if (hit >= 0) begin
          for (int j = hit; j < model_target_cnt - 1; j++)
            model_targets[j] = model_targets[j + 1];
          model_target_cnt--;
        end
      end

      st.stop_here = at_floor &&
        (target_queued(here) ||
         (dir == DIR_UP && model_up_calls[here]) ||
         (dir == DIR_DOWN && model_down_calls[here]) ||
         (model_target_cnt > 0 && model_targets[0] == car && here == car));
      st.cab_lamps = '0;
      for (int i = 0; i < model_target_cnt; i++)
        if (!(at_floor && model_targets[i] == here)) st.cab_lamps[model_targets[i]] = 1'b1;
      st.up_lamps = model_up_calls;
      st.up_lamps[NUM_FLOORS - 1] = 1'b0;
      st.down_lamps = model_down_calls;
      st.down_lamps[0] = 1'b0;
      st.next_target = (model_target_cnt > 0) ? {1'b0, model_targets[0]} : NO_TARGET;
      expected_status.push_back(st);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [IN_W-1:0] pack_tick(
    input logic [3:0] hall_up, input logic [3:0] hall_dn, input logic [3:0] cab,
    input int sensor, input logic stopped, input logic [1:0] car,
    input logic [1:0] dir, input logic rem_valid, input logic [1:0] rem_floor);
    logic [IN_W-1:0] w;
    logic [2:0]      s3;
    s3 = sensor[2:0];
    w = '0;
    w[IN_HALL_UP_LSB +: 4]         = hall_up;
    w[IN_HALL_DN_LSB +: 4]         = hall_dn;
    w[IN_CAB_LSB +: 4]             = cab;
    w[IN_SENSOR_LSB +: 3]          = s3;
    w[IN_STOPPED_BIT]              = stopped;
    w[IN_CAR_FLOOR_LSB +: FLOOR_W] = car;
    w[IN_MOTOR_DIR_LSB +: 2]       = dir;
    w[IN_REM_VALID_BIT]            = rem_valid;
    w[IN_REM_FLOOR_LSB +: FLOOR_W] = rem_floor;
    return w;
  endfunction

  // Mostly plausible traffic: sparse buttons, sensor usually on the car's floor,
  // frequent removals so the queue keeps churning.
  function automatic logic [IN_W-1:0] random_tick();
    logic [3:0] hall_up, hall_dn, cab;
    logic [1:0] car, dir;
    int         sensor, pick;
    hall_up = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
    hall_dn = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
    cab     = ($urandom_range(0, 9) < 4) ? 4'($urandom_range(0, 15)) : 4'd0;
    car     = 2'($urandom_range(0, 3));
    pick    = $urandom_range(0, 9);
    if (pick < 7)
      sensor = ($urandom_range(0, 2) != 0) ? int'(car) : $urandom_range(0, 3);
    else if (pick < 9)
      sensor = -1;
    else
      sensor = $urandom_range(4, 6);  // other negative codes
    dir = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    return pack_tick(hall_up, hall_dn, cab, sensor, 1'($urandom_range(0, 1)), car, dir,
                     ($urandom_range(0, 9) < 4), 2'($urandom_range(0, 3)));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers pending ticks, predicts on every accepted transaction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) dispatch_tick(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (pending_ticks.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_ticks.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: scores each result transaction against the oldest expectation
  // ---------------------------------------------------------------------------

  task automatic check_status(input logic [OUT_W-1:0] got);
    lamp_status_t want;
    begin
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatch_cnt++;
      end else begin
        want = expected_status.pop_front();
        if (got[0] !== want.stop_here) begin
          $display("%0t: stop_here expected %b actual %b", $time, want.stop_here, got[0]);
          mismatch_cnt++;
        end
        if (got[4:1] !== want.up_lamps) begin
          $display("%0t: up_lamps expected %b actual %b", $time, want.up_lamps, got[4:1]);
          mismatch_cnt++;
        end
        if (got[8:5] !== want.down_lamps) begin
          $display("%0t: down_lamps expected %b actual %b", $time, want.down_lamps, got[8:5]);
          mismatch_cnt++;
        end
        if (got[12:9] !== want.cab_lamps) begin
          $display("%0t: cab_lamps expected %b actual %b", $time, want.cab_lamps, got[12:9]);
          mismatch_cnt++;
        end
        if (got[15:13] !== want.next_target) begin
          $display("%0t: next_target expected %b actual %b", $time, want.next_target,
                   got[15:13]);
          mismatch_cnt++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_status(m_tdata);
      m_tready <= !hold_rx && ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Watchdog: any transaction on either side resets the count
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  task automatic drain();
    while (pending_ticks.size() != 0 || s_tvalid || expected_status.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sender idles 26%, receiver 62%
    src_idle_pct = 26;
    snk_idle_pct = 62;

    // empty state, between floors
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'h0, -1, 1'b0, 2'd0, DIR_IDLE, 1'b0, 2'd0));
    // stopped at floor 2: every hall call latched except floor 2 and the ignored bits
    pending_ticks.push_back(pack_tick(4'hF, 4'hF, 4'h0, 2, 1'b1, 2'd2, DIR_IDLE, 1'b0, 2'd0));
    // moving up through floor 2 with an up call there
    pending_ticks.push_back(pack_tick(4'h4, 4'h0, 4'h0, 2, 1'b0, 2'd2, DIR_UP, 1'b0, 2'd0));
    // every cab button between floors: queue 0,1,2,3
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'hF, -1, 1'b0, 2'd1, DIR_UP, 1'b0, 2'd0));
    // remove the last entry, a middle one, an absent one, then the head
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'h0, -1, 1'b0, 2'd1, DIR_UP, 1'b1, 2'd3));
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'h0, -1, 1'b0, 2'd1, DIR_UP, 1'b1, 2'd1));
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'h0, -1, 1'b0, 2'd1, DIR_UP, 1'b1, 2'd3));
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'h0, -1, 1'b0, 2'd1, DIR_UP, 1'b1, 2'd0));
    // cab press at the sensed floor is dropped, new ones appended after the head
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'hF, 1, 1'b1, 2'd1, DIR_IDLE, 1'b0, 2'd0));
    // queued floor equal to car floor and sensor
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'h0, 2, 1'b0, 2'd2, DIR_IDLE, 1'b0, 2'd0));
    // moving down at floor 3 with a down call there
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'h0, 3, 1'b0, 2'd3, DIR_DOWN, 1'b0, 2'd0));
    // unknown direction acts as idle even with an up call at the floor
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'h0, 1, 1'b0, 2'd1, 2'd3, 1'b0, 2'd0));
    // the other negative sensor codes
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'h2, -4, 1'b0, 2'd1, DIR_UP, 1'b0, 2'd0));
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'h0, -3, 1'b1, 2'd0, DIR_DOWN, 1'b0, 2'd0));
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'h0, -2, 1'b0, 2'd3, DIR_UP, 1'b0, 2'd0));
    // removal request ignored without its valid bit
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'h0, -1, 1'b0, 2'd0, DIR_IDLE, 1'b0, 2'd3));
    // press and removal of the same floor in one tick
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'h2, -1, 1'b0, 2'd0, DIR_UP, 1'b1, 2'd1));
    // everything high
    pending_ticks.push_back(pack_tick(4'hF, 4'hF, 4'hF, 3, 1'b1, 2'd3, 2'd3, 1'b1, 2'd3));
    // empty the queue again
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'h0, 0, 1'b0, 2'd0, DIR_UP, 1'b1, 2'd2));
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'h0, 0, 1'b0, 2'd0, DIR_UP, 1'b1, 2'd0));
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'h0, 0, 1'b0, 2'd0, DIR_DOWN, 1'b1, 2'd1));
    pending_ticks.push_back(pack_tick(4'h0, 4'h0, 4'h0, 0, 1'b0, 2'd0, DIR_IDLE, 1'b1, 2'd3));
    drain();

    // random traffic with a long receiver hold-off up front: input backs up
    for (int n = 0; n < 340; n++) pending_ticks.push_back(random_tick());
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_rx = 1'b0;
    drain();

    // sender idles 62%, receiver 26%
    src_idle_pct = 62;
    snk_idle_pct = 26;
    for (int n = 0; n < 370; n++) pending_ticks.push_back(random_tick());
    drain();

    // back to back, no idling
    src_idle_pct = 0;
    snk_idle_pct = 0;
    for (int n = 0; n < 370; n++) pending_ticks.push_back(random_tick());
    drain();

    // catch any stray late result
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
